// ----- sv/cld_pkg.sv -----
// Package: shared constants, types and command/status structs for the line discipline.
package cld_pkg;

  localparam int unsigned EditDepth = 256;
  localparam int unsigned RingDepth = 512;
  localparam int unsigned EditAw    = $clog2(EditDepth);
  localparam int unsigned RingAw    = $clog2(RingDepth);
  localparam int unsigned CntW      = RingAw + 1;

  // Register indexes
  localparam logic [2:0] RegMode  = 3'd0;
  localparam logic [2:0] RegIntr  = 3'd1;
  localparam logic [2:0] RegQuit  = 3'd2;
  localparam logic [2:0] RegSusp  = 3'd3;
  localparam logic [2:0] RegEof   = 3'd4;
  localparam logic [2:0] RegErase = 3'd5;

  // Result kinds
  localparam logic [2:0] KindEcho   = 3'd0;
  localparam logic [2:0] KindStatus = 3'd1;
  localparam logic [2:0] KindRead   = 3'd2;
  localparam logic [2:0] KindEof    = 3'd3;
  localparam logic [2:0] KindEmpty  = 3'd4;

  // Signal codes
  localparam logic [1:0] SigNone = 2'd0;
  localparam logic [1:0] SigIntr = 2'd1;
  localparam logic [1:0] SigQuit = 2'd2;
  localparam logic [1:0] SigSusp = 2'd3;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCaret = 8'h5e;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChBsl   = 8'h5c;
  localparam logic [7:0] ChZ     = 8'h5a;
  localparam logic [7:0] ChNul   = 8'h00;

  // Decoded action of a received byte
  typedef enum logic [2:0] {
    ActNone   = 3'd0,
    ActSignal = 3'd1,
    ActEof    = 3'd2,
    ActNl     = 3'd3,
    ActErase  = 3'd4,
    ActStore  = 3'd5,
    ActRaw    = 3'd6
  } act_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch input transaction and decode
    logic edit_wr;    // write char into edit store
    logic clr_edit;   // edit length to zero
    logic dec_edit;   // edit length minus one
    logic push_edit;  // push edit read data into ring
    logic push_char;  // push pushed-char into ring
    logic push_nul;   // push zero sentinel
    logic pop;        // pop one ring byte (read issued)
    logic copy_inc;   // advance copy index
    logic copy_clr;   // reset copy index
    logic emit;       // drive one result
    logic [1:0] eidx; // echo index for this result
    logic elast;      // last result
    logic [2:0] kind;
    logic set_wake;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op;
    act_e act;
    logic echo_on;
    logic [2:0] n_echo;
    logic copy_done;
    logic ring_empty;
    logic rd_zero;
  } sts_t;

endpackage

// ----- sv/canonical_line_discipline.sv -----
// A line commit copies the edit line into the ring byte by byte before its results.
// One transaction at a time; start is taken when busy is low, results strobe one per cycle.
// Busy drops while the last result is on the ports, so the next start can meet that edge.
// Throughput is set by the edit-store to ring copy loop through the single RAM read port.
// Reset (async, active low) restores register defaults and empties line and ring;
// store contents are not cleared. The receiver cannot stall results.
module canonical_line_discipline (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       start,
  output logic       busy,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  output logic       strobe,
  output logic [2:0] kind_o,
  output logic [7:0] byte_value_o,
  output logic [1:0] signal_raised_o,
  output logic       wake_reader_o,
  output logic       overflow_o,
  output logic       last_o
);
  import cld_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cld_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .sts_i(sts), .cmd_o(cmd)
  );

  cld_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .op_i, .rx_byte_i,
    .cmd_i(cmd), .sts_o(sts), .kind_o, .byte_value_o, .signal_raised_o,
    .wake_reader_o, .overflow_o, .last_o, .strobe_o(strobe)
  );

`ifndef SYNTHESIS
  // Start is only honored when idle; last result ends the transaction
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && cmd.elast |=> !busy) else $error("busy after last result");
  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !cmd.emit) else $error("result while idle");
  a_read_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && (kind_o == KindRead || kind_o == KindEof || kind_o == KindEmpty) |-> last_o)
    else $error("read produced more than one result");
`endif
endmodule

// ----- sv/cld_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
module cld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/cld_datapath.sv -----
// Datapath: config registers, edit store, read ring, pointers and result fields.
module cld_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               op_i,
  input  logic [7:0]         rx_byte_i,
  input  cld_pkg::cmd_t      cmd_i,
  output cld_pkg::sts_t      sts_o,
  output logic [2:0]         kind_o,
  output logic [7:0]         byte_value_o,
  output logic [1:0]         signal_raised_o,
  output logic               wake_reader_o,
  output logic               overflow_o,
  output logic               last_o,
  output logic               strobe_o
);
  import cld_pkg::*;

  logic [3:0] mode_q;
  logic [7:0] intr_q, quit_q, susp_q, eof_q, erase_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 4'hf; intr_q <= 8'd3; quit_q <= 8'd28;
      susp_q <= 8'd26; eof_q <= 8'd4; erase_q <= 8'd127;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMode:  mode_q  <= cfg_data_i[3:0];
        RegIntr:  intr_q  <= cfg_data_i;
        RegQuit:  quit_q  <= cfg_data_i;
        RegSusp:  susp_q  <= cfg_data_i;
        RegEof:   eof_q   <= cfg_data_i;
        RegErase: erase_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decode of the incoming byte
  act_e       act_d;
  logic [1:0] sig_d;
  logic [7:0] mark_d, ch_d;
  logic [EditAw:0] elen_q;

  always_comb begin
    act_d  = ActNone;
    sig_d  = SigNone;
    mark_d = ChC;
    ch_d   = rx_byte_i;
    if (mode_q[0] && rx_byte_i == intr_q) begin
      sig_d = SigIntr; mark_d = ChC;
    end else if (mode_q[0] && rx_byte_i == quit_q) begin
      sig_d = SigQuit; mark_d = ChBsl;
    end else if (mode_q[0] && rx_byte_i == susp_q) begin
      sig_d = SigSusp; mark_d = ChZ;
    end
    if (mode_q[3] && rx_byte_i == ChCr) ch_d = ChLf;
    if (sig_d != SigNone) act_d = ActSignal;
    else if (!mode_q[1]) act_d = ActRaw;
    else if (ch_d == eof_q) act_d = ActEof;
    else if (ch_d == ChLf) act_d = ActNl;
    else if (ch_d == erase_q || ch_d == ChBs) act_d = (elen_q != '0) ? ActErase : ActNone;
    else if (ch_d >= ChSpace && elen_q < (EditAw+1)'(EditDepth - 1)) act_d = ActStore;
  end

  logic       op_q;
  act_e       act_q;
  logic [1:0] sig_q;
  logic [7:0] mark_q, ch_q;
  logic       wake_q, ovf_q;

  // Transaction registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= 1'b0; act_q <= ActNone; sig_q <= SigNone;
      wake_q <= 1'b0;
    end else if (cmd_i.load) begin
      op_q <= op_i; act_q <= op_i ? ActNone : act_d;
      sig_q <= op_i ? SigNone : sig_d; wake_q <= 1'b0;
    end else if (cmd_i.set_wake) begin
      wake_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mark_q <= mark_d; ch_q <= ch_d;
    end
  end

  // Edit store and length
  logic [EditAw:0]   copy_q;
  logic [7:0]        edit_rd;
  cld_ram #(.Width(8), .Depth(EditDepth)) u_edit (
    .clk_i, .we_i(cmd_i.edit_wr), .waddr_i(elen_q[EditAw-1:0]), .wdata_i(ch_q),
    .raddr_i(copy_q[EditAw-1:0]), .rdata_o(edit_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) elen_q <= '0;
    else if (cmd_i.clr_edit) elen_q <= '0;
    else if (cmd_i.dec_edit) elen_q <= elen_q - 1'b1;
    else if (cmd_i.edit_wr) elen_q <= elen_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) copy_q <= '0;
    else if (cmd_i.copy_clr) copy_q <= '0;
    else if (cmd_i.copy_inc) copy_q <= copy_q + 1'b1;
  end

  // Read ring
  logic [RingAw-1:0] head_q, tail_q;
  logic [CntW-1:0]   cnt_q;
  logic [7:0]        ring_rd, push_data;
  logic              push, push_ok, pop_ok;

  assign push      = cmd_i.push_edit | cmd_i.push_char | cmd_i.push_nul;
  assign push_ok   = push && cnt_q < CntW'(RingDepth);
  assign pop_ok    = cmd_i.pop && cnt_q != '0;
  assign push_data = cmd_i.push_edit ? edit_rd : (cmd_i.push_nul ? ChNul : ch_q);

  cld_ram #(.Width(8), .Depth(RingDepth)) u_ring (
    .clk_i, .we_i(push_ok), .waddr_i(tail_q), .wdata_i(push_data),
    .raddr_i(head_q), .rdata_o(ring_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
    end else begin
      if (cmd_i.load) ovf_q <= 1'b0;
      else if (push && !push_ok) ovf_q <= 1'b1;
      if (push_ok) tail_q <= tail_q + 1'b1;
      if (pop_ok) head_q <= head_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_ok) - CntW'(pop_ok);
    end
  end

  // Echo byte selection
  logic [7:0] echo_b;
  always_comb begin
    echo_b = ch_q;
    unique case (act_q)
      ActSignal: unique case (cmd_i.eidx)
        2'd0: echo_b = ChCaret;
        2'd1: echo_b = mark_q;
        2'd2: echo_b = ChCr;
        default: echo_b = ChLf;
      endcase
      ActNl: echo_b = (cmd_i.eidx == 2'd0) ? ChCr : ChLf;
      ActErase: echo_b = (cmd_i.eidx == 2'd1) ? ChSpace : ChBs;
      default: echo_b = ch_q;
    endcase
  end

  // Status to controller
  always_comb begin
    sts_o.op         = op_q;
    sts_o.act        = act_q;
    sts_o.echo_on    = mode_q[2];
    sts_o.copy_done  = copy_q >= elen_q;
    sts_o.ring_empty = cnt_q == '0;
    sts_o.rd_zero    = ring_rd == ChNul;
    unique case (act_q)
      ActSignal:         sts_o.n_echo = 3'd4;
      ActNl:             sts_o.n_echo = 3'd2;
      ActErase:          sts_o.n_echo = 3'd3;
      ActStore, ActRaw:  sts_o.n_echo = 3'd1;
      default:           sts_o.n_echo = 3'd0;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) strobe_o <= 1'b0;
    else strobe_o <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o          <= cmd_i.kind;
      last_o          <= cmd_i.elast;
      signal_raised_o <= sig_q;
      wake_reader_o   <= op_q ? 1'b0 : wake_q;
      overflow_o      <= op_q ? 1'b0 : ovf_q;
      unique case (cmd_i.kind)
        KindEcho: byte_value_o <= echo_b;
        KindRead: byte_value_o <= ring_rd;
        default:  byte_value_o <= 8'd0;
      endcase
    end
  end
endmodule

// ----- sv/cld_ctrl.sv -----
// Controller: sequences decode, edit update, commit copy and result emission.
module cld_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cld_pkg::sts_t sts_i,
  output cld_pkg::cmd_t cmd_o
);
  import cld_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StExec  = 7'b0000010,
    StCopyR = 7'b0000100,
    StCopyW = 7'b0001000,
    StTail  = 7'b0010000,
    StRead  = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] eidx_q, eidx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; eidx_q <= 2'd0;
    end else begin
      state_q <= state_d; eidx_q <= eidx_d;
    end
  end

  assign busy_o = state_q != StIdle;

  always_comb begin
    logic [2:0] n;
    n       = sts_i.echo_on ? sts_i.n_echo : 3'd0;
    cmd_o   = '0;
    state_d = state_q;
    eidx_d  = eidx_q;
    unique case (state_q)
      StIdle: if (start_i) begin
        cmd_o.load = 1'b1; cmd_o.copy_clr = 1'b1; eidx_d = 2'd0;
        state_d = StExec;
      end
      StExec: if (sts_i.op) begin
        if (sts_i.ring_empty) begin
          cmd_o.emit = 1'b1; cmd_o.kind = KindEmpty; cmd_o.elast = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.pop = 1'b1; state_d = StRead;
        end
      end else begin
        unique case (sts_i.act)
          ActSignal: begin cmd_o.clr_edit = 1'b1; state_d = StEmit; end
          ActErase:  begin cmd_o.dec_edit = 1'b1; state_d = StEmit; end
          ActStore:  begin cmd_o.edit_wr = 1'b1; state_d = StEmit; end
          ActRaw:    begin
            cmd_o.push_char = 1'b1; cmd_o.set_wake = 1'b1; state_d = StEmit;
          end
          ActEof, ActNl: begin cmd_o.set_wake = 1'b1; state_d = StCopyR; end
          default: state_d = StEmit;
        endcase
      end
      // Edit-to-ring copy: one read, then one push per byte
      StCopyR: if (sts_i.copy_done) begin
        state_d = StTail;
      end else begin
        state_d = StCopyW;
      end
      StCopyW: begin
        cmd_o.push_edit = 1'b1; cmd_o.copy_inc = 1'b1; state_d = StCopyR;
      end
      StTail: begin
        cmd_o.clr_edit = 1'b1;
        if (sts_i.act == ActEof) cmd_o.push_nul = 1'b1;
        else cmd_o.push_char = 1'b1;
        state_d = StEmit;
      end
      StRead: begin
        cmd_o.emit = 1'b1; cmd_o.elast = 1'b1;
        cmd_o.kind = sts_i.rd_zero ? KindEof : KindRead;
        state_d = StIdle;
      end
      StEmit: begin
        cmd_o.emit = 1'b1; cmd_o.eidx = eidx_q;
        if (n == 3'd0) begin
          cmd_o.kind = KindStatus; cmd_o.elast = 1'b1; state_d = StIdle;
        end else begin
          cmd_o.kind = KindEcho;
          cmd_o.elast = {1'b0, eidx_q} == n - 3'd1;
          eidx_d = eidx_q + 2'd1;
          if (cmd_o.elast) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// ----- tb/sv/canonical_line_discipline_tb.sv -----
// Testbench for the terminal input line discipline: directed table, random traffic, predictor.
`timescale 1ns / 100ps

module canonical_line_discipline_tb;
  import cld_pkg::*;

  localparam int unsigned TimeoutCycles = 1_000_000;
  localparam int unsigned DrainCycles   = 600;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       start = 1'b0;
  logic       busy;
  logic       op_i = 1'b0;
  logic [7:0] rx_byte_i = '0;
  logic       strobe;
  logic [2:0] kind_o;
  logic [7:0] byte_value_o;
  logic [1:0] signal_raised_o;
  logic       wake_reader_o;
  logic       overflow_o;
  logic       last_o;

  canonical_line_discipline u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start, .busy, .op_i, .rx_byte_i,
    .strobe, .kind_o, .byte_value_o, .signal_raised_o,
    .wake_reader_o, .overflow_o, .last_o
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [1:0] sig;
    logic       wake;
    logic       ovf;
    logic       last;
  } tty_res_t;

  // Shadow registers and line/ring state
  logic [3:0] mode_q;
  logic [7:0] intr_q, quit_q, susp_q, eof_q, erase_q;
  logic [7:0] edit_shadow[EditDepth];
  int unsigned line_len;
  logic [7:0] ring_buf[RingDepth];
  int unsigned ring_rd, ring_wr, ring_fill;
  bit ring_drop;

  tty_res_t   pending_q[$];
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;

  task automatic ring_push(input logic [7:0] b);
    if (ring_fill >= RingDepth) begin
      ring_drop = 1'b1;
    end else begin
      ring_buf[ring_wr] = b;
      ring_wr = (ring_wr + 1) % RingDepth;
      ring_fill++;
    end
  endtask

  // Predict results of one transaction and queue them
  task automatic predict_tty(input logic op, input logic [7:0] rx);
    logic [7:0] ch;
    logic [7:0] echo[4];
    int ne;
    logic [1:0] sig;
    logic wake;
    logic [7:0] mark;
    logic [7:0] b;
    tty_res_t r;
    ch = rx;
    ne = 0;
    sig = SigNone;
    wake = 1'b0;
    mark = '0;
    if (op) begin
      r = '0;
      r.last = 1'b1;
      if (ring_fill == 0) begin
        r.kind = KindEmpty;
      end else begin
        b = ring_buf[ring_rd];
        ring_rd = (ring_rd + 1) % RingDepth;
        ring_fill--;
        if (b == ChNul) r.kind = KindEof;
        else begin
          r.kind = KindRead;
          r.value = b;
        end
      end
      pending_q.push_back(r);
      return;
    end
    ring_drop = 1'b0;
    if (mode_q[0]) begin
      if (ch == intr_q) begin
        sig = SigIntr; mark = ChC;
      end else if (ch == quit_q) begin
        sig = SigQuit; mark = ChBsl;
      end else if (ch == susp_q) begin
        sig = SigSusp; mark = ChZ;
      end
    end
    if (sig != SigNone) begin
      line_len = 0;
      if (mode_q[2]) begin
        echo[0] = ChCaret; echo[1] = mark; echo[2] = ChCr; echo[3] = ChLf;
        ne = 4;
      end
    end else begin
      if (mode_q[3] && ch == ChCr) ch = ChLf;
      if (mode_q[1]) begin
        if (ch == eof_q) begin
          for (int i = 0; i < line_len; i++) ring_push(edit_shadow[i]);
          line_len = 0;
          ring_push(ChNul);
          wake = 1'b1;
        end else if (ch == ChLf) begin
          if (mode_q[2]) begin
            echo[0] = ChCr; echo[1] = ChLf; ne = 2;
          end
          for (int i = 0; i < line_len; i++) ring_push(edit_shadow[i]);
          line_len = 0;
          ring_push(ChLf);
          wake = 1'b1;
        end else if (ch == erase_q || ch == ChBs) begin
          if (line_len > 0) begin
            line_len--;
            if (mode_q[2]) begin
              echo[0] = ChBs; echo[1] = ChSpace; echo[2] = ChBs; ne = 3;
            end
          end
        end else if (ch >= ChSpace && line_len < EditDepth - 1) begin
          edit_shadow[line_len] = ch;
          line_len++;
          if (mode_q[2]) begin
            echo[0] = ch; ne = 1;
          end
        end
      end else begin
        ring_push(ch);
        if (mode_q[2]) begin
          echo[0] = ch; ne = 1;
        end
        wake = 1'b1;
      end
    end
    if (ne == 0) begin
      r = '{kind: KindStatus, value: '0, sig: sig, wake: wake, ovf: ring_drop, last: 1'b1};
      pending_q.push_back(r);
    end else begin
      for (int k = 0; k < ne; k++) begin
        r = '{kind: KindEcho, value: echo[k], sig: sig, wake: wake, ovf: ring_drop,
              last: (k == ne - 1)};
        pending_q.push_back(r);
      end
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    tty_res_t want;
    cyc_cnt <= cyc_cnt + 1;
    if (rst_ni && strobe) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d byte=%0h", kind_o, byte_value_o);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind exp %0d got %0d", want.kind, kind_o); err_cnt++;
        end
        if (byte_value_o !== want.value) begin
          $error("byte_value exp %0h got %0h", want.value, byte_value_o); err_cnt++;
        end
        if (signal_raised_o !== want.sig) begin
          $error("signal_raised exp %0d got %0d", want.sig, signal_raised_o); err_cnt++;
        end
        if (wake_reader_o !== want.wake) begin
          $error("wake_reader exp %0d got %0d", want.wake, wake_reader_o); err_cnt++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow exp %0d got %0d", want.ovf, overflow_o); err_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last exp %0d got %0d", want.last, last_o); err_cnt++;
        end
      end
    end
  end

  // Timeout watchdog
  always @(posedge clk_i) begin
    if (cyc_cnt > TimeoutCycles) begin
      $display("[canonical_line_discipline] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegMode:  mode_q  = val[3:0];
      RegIntr:  intr_q  = val;
      RegQuit:  quit_q  = val;
      RegSusp:  susp_q  = val;
      RegEof:   eof_q   = val;
      RegErase: erase_q = val;
      default: ;
    endcase
  endtask

  // Drive one transaction; random gap beforehand
  task automatic send_item(input logic op, input logic [7:0] rx);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    start     <= 1'b1;
    op_i      <= op;
    rx_byte_i <= rx;
    @(posedge clk_i);
    predict_tty(op, rx);
    @(negedge clk_i);
    start     <= 1'b0;
    op_i      <= 1'($urandom_range(0, 1));
    rx_byte_i <= 8'($urandom_range(0, 255));
  endtask

  // Wait until idle so registers can be rewritten
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Directed table; exp_kind/exp_val checked only where chk is set
  typedef struct {
    logic       op;
    logic [7:0] rx;
    bit         chk;
    logic [2:0] exp_kind;
    logic [7:0] exp_val;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{1'b1, 8'h00, 1'b1, KindEmpty,  8'h00},  // read on empty ring
    '{1'b0, 8'h7f, 1'b1, KindStatus, 8'h00},  // erase on empty line
    '{1'b0, 8'h01, 1'b1, KindStatus, 8'h00},  // ignored control byte
    '{1'b0, 8'h41, 1'b1, KindEcho,   8'h41},
    '{1'b0, 8'hff, 1'b1, KindEcho,   8'hff},  // high bytes are printable
    '{1'b0, 8'h20, 1'b1, KindEcho,   8'h20},
    '{1'b0, 8'h08, 1'b1, KindEcho,   8'h08},  // backspace
    '{1'b0, 8'h7f, 1'b0, KindEcho,   8'h00},
    '{1'b0, 8'h42, 1'b0, KindEcho,   8'h00},
    '{1'b0, 8'h0d, 1'b1, KindEcho,   8'h0d},  // CR mapped to newline
    '{1'b1, 8'h00, 1'b1, KindRead,   8'h41},
    '{1'b1, 8'hff, 1'b0, KindRead,   8'h00},
    '{1'b1, 8'h00, 1'b0, KindRead,   8'h00},
    '{1'b0, 8'h43, 1'b0, KindEcho,   8'h00},
    '{1'b0, 8'h04, 1'b1, KindStatus, 8'h00},  // EOF commits plus sentinel
    '{1'b1, 8'h00, 1'b0, KindRead,   8'h00},
    '{1'b1, 8'h00, 1'b1, KindEof,    8'h00},
    '{1'b0, 8'h03, 1'b1, KindEcho,   8'h5e},  // interrupt
    '{1'b0, 8'h1c, 1'b1, KindEcho,   8'h5e},  // quit
    '{1'b0, 8'h1a, 1'b1, KindEcho,   8'h5e},  // stop
    '{1'b0, 8'h04, 1'b0, KindEcho,   8'h00},  // EOF on empty line
    '{1'b1, 8'h00, 1'b1, KindEof,    8'h00}
  };

  task automatic random_phase(input int n, input int raw_bias);
    logic [7:0] b;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25) send_item(1'b1, 8'($urandom_range(0, 255)));
      else if (sel < 70) send_item(1'b0, 8'($urandom_range(8'h20, 8'h7e)));
      else if (sel < 78) send_item(1'b0, $urandom_range(0, 1) ? ChCr : ChLf);
      else if (sel < 84) send_item(1'b0, $urandom_range(0, 1) ? erase_q : ChBs);
      else if (sel < 87) send_item(1'b0, eof_q);
      else if (sel < 90 + raw_bias) begin
        case ($urandom_range(0, 2))
          0: b = intr_q;
          1: b = quit_q;
          default: b = susp_q;
        endcase
        send_item(1'b0, b);
      end else send_item(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int base;
    mode_q = 4'hf; intr_q = 8'd3; quit_q = 8'd28; susp_q = 8'd26;
    eof_q = 8'd4; erase_q = 8'd127;
    line_len = 0; ring_rd = 0; ring_wr = 0; ring_fill = 0; ring_drop = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows against reset settings; earlier results checked first
    foreach (dir_tab[i]) begin
      while (pending_q.size() != 0) @(posedge clk_i);
      base = pending_q.size();
      send_item(dir_tab[i].op, dir_tab[i].rx);
      if (dir_tab[i].chk && (pending_q[base].kind !== dir_tab[i].exp_kind ||
          pending_q[base].value !== dir_tab[i].exp_val)) begin
        $error("directed row %0d predicts kind %0d byte %0h", i,
               pending_q[base].kind, pending_q[base].value);
        err_cnt++;
      end
    end

    // Random traffic, default settings
    random_phase(100, 0);
    drain();

    // Odd characters and register extremes
    cfg_write(RegMode,  8'hff);
    cfg_write(RegIntr,  8'hff);
    cfg_write(RegQuit,  8'h00);
    cfg_write(RegSusp,  8'h41);
    cfg_write(RegEof,   8'h0d);
    cfg_write(RegErase, 8'h80);
    cfg_write(3'd7,     8'h55);  // unknown index ignored
    random_phase(60, 10);
    drain();

    // Raw echo off, signals on
    cfg_write(RegMode,  8'h01);
    cfg_write(RegIntr,  8'h03);
    cfg_write(RegQuit,  8'h1c);
    cfg_write(RegSusp,  8'h1a);
    cfg_write(RegEof,   8'h04);
    cfg_write(RegErase, 8'h7f);
    random_phase(60, 5);
    drain();

    // Canonical, no signals, no CR mapping
    cfg_write(RegMode, 8'h06);
    random_phase(60, 0);
    drain();

    if (err_cnt == 0) begin
      $display("[canonical_line_discipline] OK");
    end else begin
      $display("[canonical_line_discipline] ERROR");
    end
    $finish;
  end

endmodule
